[rtl/core/fbss_pkg.sv]
// ----------------------------------------------------------------------------
// fbss_pkg
// Shared types, constants and helpers for the free binding slot scanner.
// ----------------------------------------------------------------------------
package fbss_pkg;

    // Slot bitmap size and derived widths
    localparam int SLOT_COUNT  = 64;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_N     = SLOT_COUNT / GROUP_SIZE;
    localparam int GROUP_IDX_W = $clog2(GROUP_SIZE);
    localparam int GROUP_SEL_W = $clog2(GROUP_N);

    // Register and field widths
    localparam int MAXB_W  = 7;
    localparam int ACC_W   = 7;
    localparam int WORD_W  = 3;
    localparam int BYTE_W  = 8;

    localparam logic [MAXB_W-1:0] MAXB_RESET = 7'd16;
    localparam logic [ACC_W-1:0]  ACC_MAX    = 7'd127;
    localparam logic [WORD_W-1:0] WORD_LEN   = 3'd7;

    // Characters
    localparam logic [BYTE_W-1:0] CH_B     = 8'h62;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
    localparam logic [BYTE_W-1:0] CH_G     = 8'h67;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Parser modes
    typedef enum logic [1:0] {
        MODE_SEEK    = 2'd0,
        MODE_WAIT_EQ = 2'd1,
        MODE_SKIP_WS = 2'd2,
        MODE_DIGITS  = 2'd3
    } mode_t;

    // One step of the keyword matcher
    typedef struct packed {
        logic [WORD_W-1:0] matched;
        logic              hit;
    } seek_res_t;

    // Request strobe from parser to search pipeline
    typedef struct packed {
        logic valid;
    } req_hs_t;

    function automatic logic [BYTE_W-1:0] word_char(input logic [WORD_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            3'd0:    ch = CH_B;
            3'd1:    ch = CH_I;
            3'd2:    ch = CH_N;
            3'd3:    ch = CH_D;
            3'd4:    ch = CH_I;
            3'd5:    ch = CH_N;
            3'd6:    ch = CH_G;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    function automatic seek_res_t seek_step(input logic [WORD_W-1:0] k,
                                            input logic [BYTE_W-1:0] c);
        seek_res_t r;
        r.hit     = 1'b0;
        r.matched = '0;
        if (k < WORD_LEN && c == word_char(k)) begin
            if (k == WORD_LEN - 3'd1) begin
                r.hit = 1'b1;
            end
            else begin
                r.matched = k + 3'd1;
            end
        end
        else if (c == CH_B) begin
            r.matched = 3'd1;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[rtl/core/free_binding_slot_scanner.sv]
// ----------------------------------------------------------------------------
// free_binding_slot_scanner
// Top level: configuration register, parser and free-slot search.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while in_stall is low and, on the
// byte flagged last, returns one request with the highest unused binding
// number below max_bindings (found = 0 when every slot is taken). Throughput
// is one byte per clock while the input is not stalled, as the parser state
// and the used-slot bitmap are updated once per accepted byte. The report
// passes the input register, then two registered stages of the
// highest-free-bit search, then the result register. Input stalls only when
// a report is pending and all search stages are full.
// max_bindings resets to 16 and may be written at any time the block is idle.
module free_binding_slot_scanner
    import fbss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MAXB_W-1:0]     cfg_max_bindings,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  is_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [SLOT_W-1:0]     free_slot
);

    logic [MAXB_W-1:0]     max_bindings_reg;
    req_hs_t               req_hs;
    logic                  req_ready;
    logic [SLOT_COUNT-1:0] req_free;

    assign cfg_ready = 1'b1;

    // Capture the slot count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bindings_reg <= MAXB_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            max_bindings_reg <= cfg_max_bindings;
        end
    end

    fbss_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .is_last      (is_last),
        .max_bindings (max_bindings_reg),
        .req_hs_out   (req_hs),
        .req_ready    (req_ready),
        .req_free     (req_free)
    );

    fbss_search u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_hs_in (req_hs),
        .req_ready (req_ready),
        .req_free  (req_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .free_slot (free_slot)
    );

endmodule

[rtl/core/fbss_parser.sv]
// ----------------------------------------------------------------------------
// fbss_parser
// Input register, keyword/number parser and used-slot bitmap. Emits the
// free-slot vector on the last byte of the text.
// ----------------------------------------------------------------------------
module fbss_parser
    import fbss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [BYTE_W-1:0]       text_byte,
    input  logic                    is_last,
    input  logic [MAXB_W-1:0]       max_bindings,
    output req_hs_t                 req_hs_out,
    input  logic                    req_ready,
    output logic [SLOT_COUNT-1:0]   req_free
);

    logic                  s0_valid_reg;
    logic [BYTE_W-1:0]     s0_byte_reg;
    logic                  s0_last_reg;
    logic                  s0_take;

    mode_t                 mode_reg, mode_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  seen_reg, seen_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;

    logic                  mark_en;
    logic [ACC_W-1:0]      mark_val;
    logic [SLOT_COUNT-1:0] mark_vec;
    logic [SLOT_COUNT-1:0] used_final;
    logic [SLOT_COUNT-1:0] limit_mask;
    logic [MAXB_W-1:0]     limit;

    seek_res_t             seek_cur;
    seek_res_t             seek_new;
    logic [3:0]            digit_val;
    logic [10:0]           acc_ext;
    logic [10:0]           acc_sum;

    // Consume the held byte unless it is last and the search stage is full
    assign s0_take   = s0_valid_reg && (!s0_last_reg || req_ready);
    assign in_stall  = s0_valid_reg && !s0_take;

    assign req_hs_out.valid = s0_take && s0_last_reg;

    // Hold the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall) begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_take) begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s0_byte_reg <= text_byte;
            s0_last_reg <= is_last;
        end
    end

    assign seek_cur  = seek_step(word_reg, s0_byte_reg);
    assign seek_new  = seek_step('0, s0_byte_reg);
    assign digit_val = 4'(s0_byte_reg - CH_ZERO);
    assign acc_ext   = 11'(acc_reg);
    assign acc_sum   = (acc_ext << 3) + (acc_ext << 1) + 11'(digit_val);

    // Next parser state
    always_comb
    begin
        mode_next = mode_reg;
        word_next = word_reg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        mark_en   = 1'b0;
        mark_val  = acc_reg;
        case (mode_reg)
            MODE_WAIT_EQ: begin
                if (s0_byte_reg == CH_EQ) begin
                    mode_next = MODE_SKIP_WS;
                end
            end
            MODE_SKIP_WS: begin
                if (is_space(s0_byte_reg)) begin
                    mode_next = MODE_SKIP_WS;
                end
                else if (is_digit(s0_byte_reg)) begin
                    mode_next = MODE_DIGITS;
                    seen_next = 1'b1;
                    acc_next  = ACC_W'(digit_val);
                end
                else begin
                    mode_next = seek_new.hit ? MODE_WAIT_EQ : MODE_SEEK;
                    word_next = seek_new.matched;
                end
            end
            MODE_DIGITS: begin
                if (is_digit(s0_byte_reg)) begin
                    acc_next = (acc_sum > 11'(ACC_MAX)) ? ACC_MAX : ACC_W'(acc_sum);
                end
                else begin
                    mark_en   = seen_reg;
                    seen_next = 1'b0;
                    acc_next  = '0;
                    mode_next = seek_new.hit ? MODE_WAIT_EQ : MODE_SEEK;
                    word_next = seek_new.matched;
                end
            end
            default: begin
                mode_next = seek_cur.hit ? MODE_WAIT_EQ : MODE_SEEK;
                word_next = seek_cur.matched;
            end
        endcase
    end

    // Bitmap update and free-slot vector for the report
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            mark_vec[i] = (mark_en && mark_val == ACC_W'(i))
                || (s0_last_reg && mode_next == MODE_DIGITS && seen_next
                    && acc_next == ACC_W'(i));
        end
        used_final = used_reg | mark_vec;
        used_next  = used_final;
        limit      = (max_bindings > MAXB_W'(SLOT_COUNT)) ? MAXB_W'(SLOT_COUNT)
                                                          : max_bindings;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            limit_mask[i] = MAXB_W'(i) < limit;
        end
        req_free = ~used_final & limit_mask;
    end

    // Advance parser state; clear it after the report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_SEEK;
            word_reg <= '0;
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            used_reg <= '0;
        end
        else if (s0_take) begin
            if (s0_last_reg) begin
                mode_reg <= MODE_SEEK;
                word_reg <= '0;
                acc_reg  <= '0;
                seen_reg <= 1'b0;
                used_reg <= '0;
            end
            else begin
                mode_reg <= mode_next;
                word_reg <= word_next;
                acc_reg  <= acc_next;
                seen_reg <= seen_next;
                used_reg <= used_next;
            end
        end
    end

endmodule

[rtl/core/fbss_search.sv]
// ----------------------------------------------------------------------------
// fbss_search
// Registered two-level search for the highest set bit of the free-slot
// vector, ending in the result register.
// ----------------------------------------------------------------------------
module fbss_search
    import fbss_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  req_hs_t                 req_hs_in,
    output logic                    req_ready,
    input  logic [SLOT_COUNT-1:0]   req_free,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    found,
    output logic [SLOT_W-1:0]       free_slot
);

    logic                          s1_valid_reg;
    logic [SLOT_COUNT-1:0]         s1_free_reg;
    logic                          s2_valid_reg;
    logic [GROUP_N-1:0]            s2_any_reg, s2_any_next;
    logic [GROUP_IDX_W-1:0]        s2_idx_reg [GROUP_N];
    logic [GROUP_IDX_W-1:0]        s2_idx_next [GROUP_N];
    logic                          out_valid_reg;
    logic                          found_reg, found_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;

    logic                          out_ready;
    logic                          s2_ready;
    logic                          s1_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;

    // Hold the free vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready) begin
            s1_valid_reg <= req_hs_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req_hs_in.valid) begin
            s1_free_reg <= req_free;
        end
    end

    // Find the highest free bit within each group
    always_comb
    begin
        for (int g = 0; g < GROUP_N; g++) begin
            s2_any_next[g] = |s1_free_reg[g*GROUP_SIZE +: GROUP_SIZE];
            s2_idx_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (s1_free_reg[g*GROUP_SIZE + j]) begin
                    s2_idx_next[g] = GROUP_IDX_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg) begin
            s2_any_reg <= s2_any_next;
            s2_idx_reg <= s2_idx_next;
        end
    end

    // Pick the highest group that has a free bit
    always_comb
    begin
        found_next = 1'b0;
        slot_next  = '0;
        for (int g = 0; g < GROUP_N; g++) begin
            if (s2_any_reg[g]) begin
                found_next = 1'b1;
                slot_next  = SLOT_W'({GROUP_SEL_W'(g), s2_idx_reg[g]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready) begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg) begin
            found_reg <= found_next;
            slot_reg  <= slot_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign free_slot = slot_reg;

endmodule

[rtl/core/fbss_checker.sv]
// ----------------------------------------------------------------------------
// fbss_checker
// Port-level checks for the free binding slot scanner, bound to the top.
// ----------------------------------------------------------------------------
module fbss_checker
    import fbss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  is_last,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  found,
    input  logic [SLOT_W-1:0]     free_slot
);

    // Hold a stalled result request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(free_slot))
    else $error("stalled result changed");

    // Expect a stalled input request to stay put
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(text_byte) && $stable(is_last))
    else $error("stalled input request changed");

    // Report zero slot when none is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> free_slot == '0)
    else $error("free_slot nonzero without found");

    // Stall input only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while result path is free");

    // Accept configuration writes at once
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write not accepted");

endmodule

bind free_binding_slot_scanner fbss_checker u_fbss_checker (.*);
